// File: rtl/lssa_pkg.sv
// Shared types and constants for the level sensor smoothing and alarm core.
// No dependencies; imported by level_sensor_smoothing_alarm_core.
package lssa_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_ALM
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAW_EMPTY = 2'd0;
    localparam logic [1:0] CFG_RAW_FULL  = 2'd1;
    localparam logic [1:0] CFG_ALARM_THR = 2'd2;
    localparam logic [1:0] CFG_READ_INT  = 2'd3;

    // Level format: signed, 1/256 percent
    localparam int LEVEL_W     = 17;
    localparam int LEVEL_MAX   = 65535;
    localparam int LEVEL_MIN   = -65536;
    localparam int LEVEL_RESET = 12800;
    localparam int HYST_BAND   = 1280;
    localparam int THR_W       = 15;
    localparam int INTERVAL_W  = 16;
    localparam int SECONDS_W   = 6;
    localparam int CFG_DATA_W  = 16;

    // Decay divisor, and term scale 2560 = 2^11 + 2^9
    localparam int DECAY_DIV   = 10;
    localparam int TERM_SH_HI  = 11;
    localparam int TERM_SH_LO  = 9;
    localparam int TERM_W      = 12;

endpackage

// File: rtl/level_sensor_smoothing_alarm_core.sv
// Level sensor smoothing with hysteresis low-level alarm, top level.
// Depends on lssa_pkg (types, register indexes, level constants).
// Holds the interval counter, two bit-serial dividers and the output stage.

// Each input transaction carries the seconds value of a clock and one raw
// sensor sample. A change of the seconds value steps an interval counter;
// once the counter reaches read_interval it clears and the sample is taken
// (read_interval 0 takes every sample). A taken sample updates the smoothed
// level to level*9/10 + (raw-empty)*2560/(full-empty), both quotients
// truncated toward zero, the term zero when full equals empty, the sum
// saturated to -65536..65535 (1/256 percent). The alarm then sets when the
// level is below alarm_threshold and clears when it is above the threshold
// plus 5 percent; one output transaction follows. An item that takes no
// sample is absorbed and gives no output. A taken sample occupies the
// block through these steps in order: accept, the two restoring dividers
// that retire one quotient bit per cycle side by side, add and saturate,
// and update the alarm and load the output register. The output register
// frees the input side: a new item is taken while a result waits on the
// master side; only the final load waits for that register. Write
// configuration only while the block is idle.
module level_sensor_smoothing_alarm_core
    import lssa_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: seconds_now[5:0], raw_sample[SAMPLE_BITS+5:6], zero fill
    input  logic [((SECONDS_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: level_out[16:0], alarm_out[17], raw_out[SAMPLE_BITS+17:18], zero fill
    output logic [((LEVEL_W + 1 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int OUT_BITS = LEVEL_W + 1 + SAMPLE_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    // Quotient width: |raw-empty| * 2560 needs SAMPLE_BITS+12 bits and
    // |level| * 9 needs 20, which is never more for SAMPLE_BITS >= 8.
    localparam int NUM_W    = SAMPLE_BITS + TERM_W;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int SUM_W    = NUM_W + 2;
    localparam int DRM_W    = $clog2(DECAY_DIV);
    localparam int DIFF_W   = SAMPLE_BITS + 1;

    localparam logic signed [SUM_W-1:0]   SUM_HI   = SUM_W'(LEVEL_MAX);
    localparam logic signed [SUM_W-1:0]   SUM_LO   = SUM_W'(LEVEL_MIN);
    localparam logic [DRM_W:0]            DDIV     = (DRM_W + 1)'(DECAY_DIV);
    localparam logic [CNT_W-1:0]          CNT_LAST = CNT_W'(NUM_W - 1);
    localparam logic signed [LEVEL_W:0]   HYST     = (LEVEL_W + 1)'(HYST_BAND);

    // Configuration registers
    logic [SAMPLE_BITS-1:0] r_raw_empty;
    logic [SAMPLE_BITS-1:0] r_raw_full;
    logic [THR_W-1:0]       r_alarm_thr;
    logic [INTERVAL_W-1:0]  r_read_int;

    // Control state
    t_state                 r_state, n_state;
    logic [SECONDS_W-1:0]   r_last_sec, n_last_sec;
    logic [INTERVAL_W-1:0]  r_int_cnt, n_int_cnt;
    logic signed [LEVEL_W-1:0] r_level, n_level;
    logic                   r_alarm, n_alarm;
    logic [CNT_W-1:0]       r_bit_cnt, n_bit_cnt;
    logic                   r_out_valid, n_out_valid;

    // Divider and payload registers
    logic [NUM_W-1:0]       r_qd, n_qd;       // decay quotient shift register
    logic [DRM_W-1:0]       r_rd, n_rd;       // decay remainder
    logic [NUM_W-1:0]       r_qt, n_qt;       // term quotient shift register
    logic [SAMPLE_BITS-1:0] r_rt, n_rt;       // term remainder
    logic [SAMPLE_BITS-1:0] r_dvt, n_dvt;     // |full - empty|
    logic                   r_neg_d, n_neg_d;
    logic                   r_neg_t, n_neg_t;
    logic                   r_span_zero, n_span_zero;
    logic [SAMPLE_BITS-1:0] r_raw, n_raw;
    logic signed [LEVEL_W-1:0] r_out_level, n_out_level;
    logic                   r_out_alarm, n_out_alarm;
    logic [SAMPLE_BITS-1:0] r_out_raw, n_out_raw;

    // Input unpack and interval decision
    logic [SECONDS_W-1:0]   w_secs;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic                   w_accept;
    logic [INTERVAL_W-1:0]  w_cnt_inc;
    logic                   w_sample;

    // Operand preparation
    logic [DIFF_W-1:0]      w_diff, w_span;
    logic [DIFF_W-1:0]      w_diff_mag, w_span_mag;
    logic [LEVEL_W-1:0]     w_lvl_mag;
    logic [NUM_W-1:0]       w_num_t, w_num_d;

    // Divider steps
    logic [DRM_W:0]         w_rd_sh, w_rd_sub;
    logic                   w_d_ge;
    logic [SAMPLE_BITS:0]   w_rt_sh, w_rt_sub;
    logic                   w_t_ge;

    // Sum, saturation, alarm
    logic signed [SUM_W-1:0] w_qd_s, w_qt_s, w_sum;
    logic signed [LEVEL_W:0] w_lvl_x, w_thr_x, w_thr_hi;
    logic                    w_out_free;

    assign w_secs   = s_axis_tdata[SECONDS_W-1:0];
    assign w_raw    = s_axis_tdata[SECONDS_W +: SAMPLE_BITS];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_cnt_inc = r_int_cnt + INTERVAL_W'(w_secs != r_last_sec);
    assign w_sample  = (w_cnt_inc >= r_read_int);

    // Signed differences, then magnitudes for the unsigned dividers
    assign w_diff     = {1'b0, w_raw} - {1'b0, r_raw_empty};
    assign w_span     = {1'b0, r_raw_full} - {1'b0, r_raw_empty};
    assign w_diff_mag = w_diff[DIFF_W-1] ? -w_diff : w_diff;
    assign w_span_mag = w_span[DIFF_W-1] ? -w_span : w_span;
    assign w_lvl_mag  = r_level[LEVEL_W-1] ? LEVEL_W'(-r_level) : LEVEL_W'(r_level);

    assign w_num_t = (NUM_W'(w_diff_mag[SAMPLE_BITS-1:0]) << TERM_SH_HI)
                   + (NUM_W'(w_diff_mag[SAMPLE_BITS-1:0]) << TERM_SH_LO);
    assign w_num_d = (NUM_W'(w_lvl_mag) << 3) + NUM_W'(w_lvl_mag);

    // One restoring step per cycle on each divider
    assign w_rd_sh  = {r_rd, r_qd[NUM_W-1]};
    assign w_d_ge   = (w_rd_sh >= DDIV);
    assign w_rd_sub = w_rd_sh - DDIV;
    assign w_rt_sh  = {r_rt, r_qt[NUM_W-1]};
    assign w_t_ge   = (w_rt_sh >= {1'b0, r_dvt});
    assign w_rt_sub = w_rt_sh - {1'b0, r_dvt};

    // Apply signs, add, saturate
    assign w_qd_s = r_neg_d ? -$signed({2'b00, r_qd}) : $signed({2'b00, r_qd});
    assign w_qt_s = r_span_zero ? '0
                  : (r_neg_t ? -$signed({2'b00, r_qt}) : $signed({2'b00, r_qt}));
    assign w_sum  = w_qd_s + w_qt_s;

    // Alarm compares on the new level
    assign w_lvl_x  = {r_level[LEVEL_W-1], r_level};
    assign w_thr_x  = $signed({{(LEVEL_W + 1 - THR_W){1'b0}}, r_alarm_thr});
    assign w_thr_hi = w_thr_x + HYST;

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Configuration: always ready; to be written only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_empty <= '0;
            r_raw_full  <= SAMPLE_BITS'(1024);
            r_alarm_thr <= '0;
            r_read_int  <= INTERVAL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RAW_EMPTY: r_raw_empty <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_RAW_FULL:  r_raw_full  <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_ALARM_THR: r_alarm_thr <= i_cfg_data[THR_W-1:0];
                CFG_READ_INT:  r_read_int  <= i_cfg_data[INTERVAL_W-1:0];
                default:       r_read_int  <= r_read_int;
            endcase
        end
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_last_sec  = r_last_sec;
        n_int_cnt   = r_int_cnt;
        n_level     = r_level;
        n_alarm     = r_alarm;
        n_bit_cnt   = r_bit_cnt;
        n_out_valid = r_out_valid;
        n_qd        = r_qd;
        n_rd        = r_rd;
        n_qt        = r_qt;
        n_rt        = r_rt;
        n_dvt       = r_dvt;
        n_neg_d     = r_neg_d;
        n_neg_t     = r_neg_t;
        n_span_zero = r_span_zero;
        n_raw       = r_raw;
        n_out_level = r_out_level;
        n_out_alarm = r_out_alarm;
        n_out_raw   = r_out_raw;
        s_axis_tready = (r_state == ST_IDLE);

        // Drop the output once the master side takes it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_last_sec = w_secs;
                    n_int_cnt  = w_sample ? '0 : w_cnt_inc;
                    if (w_sample) begin
                        n_state     = ST_DIV;
                        n_bit_cnt   = '0;
                        n_qd        = w_num_d;
                        n_rd        = '0;
                        n_qt        = w_num_t;
                        n_rt        = '0;
                        n_dvt       = w_span_mag[SAMPLE_BITS-1:0];
                        n_neg_d     = r_level[LEVEL_W-1];
                        n_neg_t     = w_diff[DIFF_W-1] ^ w_span[DIFF_W-1];
                        n_span_zero = (w_span == '0);
                        n_raw       = w_raw;
                    end
                end
            end
            ST_DIV: begin
                // Advance both dividers one quotient bit
                n_qd = {r_qd[NUM_W-2:0], w_d_ge};
                n_rd = w_d_ge ? w_rd_sub[DRM_W-1:0] : w_rd_sh[DRM_W-1:0];
                n_qt = {r_qt[NUM_W-2:0], w_t_ge};
                n_rt = w_t_ge ? w_rt_sub[SAMPLE_BITS-1:0] : w_rt_sh[SAMPLE_BITS-1:0];
                n_bit_cnt = r_bit_cnt + CNT_W'(1);
                if (r_bit_cnt == CNT_LAST) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                priority if (w_sum > SUM_HI) begin
                    n_level = LEVEL_W'(LEVEL_MAX);
                end else if (w_sum < SUM_LO) begin
                    n_level = LEVEL_W'(LEVEL_MIN);
                end else begin
                    n_level = w_sum[LEVEL_W-1:0];
                end
                n_state = ST_ALM;
            end
            ST_ALM: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    if (r_alarm) begin
                        n_alarm = !(w_lvl_x > w_thr_hi);
                    end else begin
                        n_alarm = (w_lvl_x < w_thr_x);
                    end
                    n_out_level = r_level;
                    n_out_alarm = n_alarm;
                    n_out_raw   = r_raw;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_sec  <= '0;
            r_int_cnt   <= '0;
            r_level     <= LEVEL_W'(LEVEL_RESET);
            r_alarm     <= 1'b0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_sec  <= n_last_sec;
            r_int_cnt   <= n_int_cnt;
            r_level     <= n_level;
            r_alarm     <= n_alarm;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qd        <= n_qd;
        r_rd        <= n_rd;
        r_qt        <= n_qt;
        r_rt        <= n_rt;
        r_dvt       <= n_dvt;
        r_neg_d     <= n_neg_d;
        r_neg_t     <= n_neg_t;
        r_span_zero <= n_span_zero;
        r_raw       <= n_raw;
        r_out_level <= n_out_level;
        r_out_alarm <= n_out_alarm;
        r_out_raw   <= n_out_raw;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_raw, r_out_alarm, r_out_level});

    // A new output transaction only comes from the alarm stage
    a_out_from_alm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_ALM))
        else $error("output valid rose outside the alarm stage");

    // A sampled item starts the dividers on the next cycle
    a_sample_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_sample) |=> (r_state == ST_DIV && r_bit_cnt == '0))
        else $error("sampled item did not start the dividers");

    // Decay remainder stays below the divisor
    a_decay_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rd < DDIV[DRM_W-1:0]))
        else $error("decay remainder out of range");

    // Term remainder stays below a nonzero divisor
    a_term_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_span_zero) |-> (r_rt < r_dvt))
        else $error("term remainder out of range");

    // Bit counter never passes the last quotient bit
    a_bit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_bit_cnt <= CNT_LAST))
        else $error("divider bit counter overran");

endmodule

// File: tb/lssa_checker.sv
`timescale 1ns / 100ps
// Scoreboard for level_sensor_smoothing_alarm_core: follows register writes and input
// transactions, predicts each smoothed level result and checks the output stream.
// Depends on lssa_pkg for register indexes and level format constants.
module lssa_checker
    import lssa_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int IN_W        = 24,
    parameter int OUT_W       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_W-1:0]       i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_W-1:0]      i_out_data,
    output int                    o_errors,
    output int                    o_outstanding,
    output int                    o_checked
);

    localparam longint TERM_SCALE = 2560;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      alarm;
        logic [SAMPLE_BITS-1:0]    raw;
    } t_level_result;

    logic [SAMPLE_BITS-1:0]    cur_empty;
    logic [SAMPLE_BITS-1:0]    cur_full;
    logic [THR_W-1:0]          cur_thr;
    logic [INTERVAL_W-1:0]     cur_interval;
    logic [SECONDS_W-1:0]      last_secs;
    logic [INTERVAL_W-1:0]     tick_count;
    logic signed [LEVEL_W-1:0] level_acc;
    logic                      alarm_on;
    t_level_result             level_due_q[$];

    // Step the interval counter; on a taken sample update level and alarm, queue the result
    task automatic take_reading(input logic [SECONDS_W-1:0] secs,
                                input logic [SAMPLE_BITS-1:0] raw);
        longint        decay;
        longint        span;
        longint        term;
        longint        sum;
        t_level_result res;
        if (secs != last_secs) begin
            tick_count = tick_count + 1'b1;
            last_secs  = secs;
        end
        if (tick_count >= cur_interval) begin
            tick_count = '0;
            decay = (longint'(level_acc) * 9) / 10;
            span  = longint'(cur_full) - longint'(cur_empty);
            term  = 0;
            if (span != 0) begin
                term = ((longint'(raw) - longint'(cur_empty)) * TERM_SCALE) / span;
            end
            sum = decay + term;
            if (sum > LEVEL_MAX) sum = LEVEL_MAX;
            if (sum < LEVEL_MIN) sum = LEVEL_MIN;
            level_acc = sum[LEVEL_W-1:0];
            if (alarm_on) begin
                if (sum > longint'(cur_thr) + HYST_BAND) alarm_on = 1'b0;
            end else if (sum < longint'(cur_thr)) begin
                alarm_on = 1'b1;
            end
            res.level = level_acc;
            res.alarm = alarm_on;
            res.raw   = raw;
            level_due_q.insert(level_due_q.size(), res);
        end
    endtask

    always @(posedge i_clk) begin
        t_level_result want;
        t_level_result got;
        if (!i_rst_n) begin
            cur_empty     = '0;
            cur_full      = SAMPLE_BITS'(1024);
            cur_thr       = '0;
            cur_interval  = INTERVAL_W'(1);
            last_secs     = '0;
            tick_count    = '0;
            level_acc     = LEVEL_W'(LEVEL_RESET);
            alarm_on      = 1'b0;
            level_due_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RAW_EMPTY: cur_empty    = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_RAW_FULL:  cur_full     = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_ALARM_THR: cur_thr      = i_cfg_data[THR_W-1:0];
                    CFG_READ_INT:  cur_interval = i_cfg_data[INTERVAL_W-1:0];
                    default: ;
                endcase
            end
            // Retire the oldest expectation before queuing a new one
            if (i_out_valid && i_out_ready) begin
                got.level = i_out_data[LEVEL_W-1:0];
                got.alarm = i_out_data[LEVEL_W];
                got.raw   = i_out_data[LEVEL_W+1 +: SAMPLE_BITS];
                if (level_due_q.size() == 0) begin
                    $display("%0t: unexpected result, level %0d alarm %0b raw %0d",
                             $time, got.level, got.alarm, got.raw);
                    o_errors++;
                end else begin
                    want = level_due_q.pop_front();
                    o_checked++;
                    if (got.level != want.level) begin
                        $display("%0t: level_out expected %0d, got %0d",
                                 $time, want.level, got.level);
                        o_errors++;
                    end
                    if (got.alarm != want.alarm) begin
                        $display("%0t: alarm_out expected %0b, got %0b",
                                 $time, want.alarm, got.alarm);
                        o_errors++;
                    end
                    if (got.raw != want.raw) begin
                        $display("%0t: raw_out expected %0d, got %0d",
                                 $time, want.raw, got.raw);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_reading(i_in_data[SECONDS_W-1:0], i_in_data[SECONDS_W +: SAMPLE_BITS]);
            end
            o_outstanding <= level_due_q.size();
        end
    end

endmodule

// File: tb/tb_level_sensor_smoothing_alarm_core.sv
`timescale 1ns / 100ps
// Stimulus and verdict for level_sensor_smoothing_alarm_core.
// Depends on lssa_pkg, the core and lssa_checker, which does all prediction and checking.
module tb_level_sensor_smoothing_alarm_core;
    import lssa_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int IN_W         = ((SECONDS_W + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((LEVEL_W + 1 + SAMPLE_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 40;   // idle time once every expected result has arrived
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 90;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = CFG_RAW_EMPTY;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;   // seconds_now, raw_sample, zero fill
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // level_out, alarm_out, raw_out, zero fill

    int chk_errors;
    int chk_outstanding;
    int chk_checked;

    int items_sent = 0;
    int settings_used = 0;
    int clock_secs = 0;
    bit valid_idling = 1'b1;
    bit ready_idling = 1'b1;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    always #6 i_clk = ~i_clk;

    level_sensor_smoothing_alarm_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lssa_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_errors      (chk_errors),
        .o_outstanding (chk_outstanding),
        .o_checked     (chk_checked)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Advance the seconds clock by one; 60 is a legal leap value
    function automatic logic [SECONDS_W-1:0] tick_secs();
        clock_secs = (clock_secs + 1) % 61;
        return SECONDS_W'(clock_secs);
    endfunction

    // Mostly a running clock, some repeats, some arbitrary 6-bit values
    function automatic logic [SECONDS_W-1:0] pick_secs();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) clock_secs = (clock_secs + 1) % 61;
        else if (r >= 90) clock_secs = $urandom_range(0, 63);
        return SECONDS_W'(clock_secs);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_raw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    // Offer one input transaction, optionally after an idle gap; keep valid high afterward
    task automatic send_item(input logic [SECONDS_W-1:0] secs,
                             input logic [SAMPLE_BITS-1:0] raw);
        logic [IN_W-1:0] word;
        int              gap;
        word = '0;
        word[SECONDS_W-1:0] = secs;
        word[SECONDS_W +: SAMPLE_BITS] = raw;
        if (valid_idling && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the core go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_regs(input int empty_v, input int full_v, input int thr_v,
                             input int interval_v);
        put_reg(CFG_RAW_EMPTY, CFG_DATA_W'(empty_v));
        put_reg(CFG_RAW_FULL, CFG_DATA_W'(full_v));
        put_reg(CFG_ALARM_THR, CFG_DATA_W'(thr_v));
        put_reg(CFG_READ_INT, CFG_DATA_W'(interval_v));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // Output side: random stalls, plus one long hold-off when requested
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (ready_idling && $urandom_range(0, 99) < 25) begin
                gap = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int p;
        int k;
        int e;
        int f;
        int t;
        int n;
        int wait_cnt;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Power-on registers: each seconds change takes a sample
        send_item(6'd0, '0);            // seconds unchanged since reset: absorbed
        send_item(6'd1, '1);            // full-scale reading
        send_item(6'd1, '0);            // repeated seconds: absorbed
        send_item(6'd60, '0);
        send_item(6'd61, 12'd2048);
        send_item(6'd63, 12'd1024);
        send_item(6'd62, 12'd512);
        settle();

        // Span of one count: the level saturates high, alarm stays off
        load_regs(0, 1, 32767, 0);
        send_item(6'd62, '1);
        send_item(6'd62, '0);
        settle();

        // Reading below empty with a tiny span: level saturates low, alarm sets
        load_regs(4094, 4095, 32767, 0);
        send_item(6'd0, '0);
        send_item(6'd0, '1);
        settle();

        // Back to high saturation: alarm clears above threshold plus hysteresis
        load_regs(0, 1, 32767, 0);
        send_item(6'd5, '1);
        settle();

        // Full below empty: the term changes sign
        load_regs(4095, 0, 25600, 0);
        send_item(6'd9, '0);
        send_item(6'd9, '1);
        send_item(6'd9, 12'd2000);
        settle();

        // Full equals empty: decay only
        load_regs(2000, 2000, 0, 0);
        send_item(6'd9, '1);
        send_item(6'd10, '0);
        send_item(6'd11, 12'd2000);
        settle();

        // Lower the read interval below the running count: next item samples
        load_regs(0, 4095, 12800, 100);
        repeat (30) send_item(tick_secs(), pick_raw());
        settle();
        put_reg(CFG_READ_INT, 16'd2);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_item(SECONDS_W'(clock_secs), pick_raw());
        settle();

        // Widest interval: a run of seconds changes that takes no sample
        load_regs(4095, 0, 0, 65535);
        valid_idling = 1'b0;
        repeat (20) send_item(tick_secs(), pick_raw());
        valid_idling = 1'b1;
        settle();

        // Random phases
        for (p = 0; p < 9; p++) begin
            e = $urandom_range(0, 4095);
            f = ($urandom_range(0, 9) == 0) ? e : $urandom_range(0, 4095);
            t = ($urandom_range(0, 9) < 2) ? 32767 : $urandom_range(0, 25600);
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(4, 40);
            case (p)
                0: begin e = 0; f = 4095; t = 0; n = 0; end
                1: begin e = 4095; f = 0; t = 25600; n = 1; end
                2: n = 0;
                8: begin e = 4095; f = 4095; t = 32767; n = 3; end
                default: ;
            endcase
            load_regs(e, f, t, n);
            valid_idling = (p != 2 && p != 4);
            ready_idling = (p != 4);
            // Hold the output side off while inputs keep coming; the core backs up
            if (p == 2) hold_off_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == PHASE_ITEMS / 2) settle();
                send_item(pick_secs(), pick_raw());
            end
            settle();
        end
        valid_idling = 1'b1;
        ready_idling = 1'b1;

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (chk_outstanding != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk_outstanding != 0) begin
            $display("%0t: %0d expected results never arrived", $time, chk_outstanding);
        end
        $display("Sent %0d input transactions, checked %0d results over %0d register settings.",
                 items_sent, chk_checked, settings_used);
        $display("Covered saturation both ways, alarm set and clear, inverted and zero span,");
        $display("interval extremes and a %0d-cycle output hold-off.", LONG_HOLD);
        if (chk_errors == 0 && chk_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
